[hw/rtl/lro_pkg.sv]
`default_nettype none

package lro_pkg;

  localparam int unsigned CFG_W   = 11;
  localparam int unsigned AREA_W  = 21;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef enum logic [APB_AW-3:0] {
    REG_NUM_COLS = 1'b0
  } lro_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREFLUSH,
    S_HGT,
    S_POP,
    S_FLUSH,
    S_DRAIN,
    S_CLEAR
  } lro_state_e;

  typedef struct packed {
    logic pop;
    logic clr;
  } lro_score_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/lro_ram.sv]
`default_nettype none

module lro_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/lro_score.sv]
`default_nettype none

module lro_score
  import lro_pkg::*;
#(
  parameter int unsigned HW    = 11,
  parameter int unsigned CNT_W = 11
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lro_score_ctl_t       ctl_i,
  input  wire logic [HW-1:0]        height_i,
  input  wire logic [CNT_W-1:0]     width_i,
  output      logic [AREA_W-1:0]    best_o,
  output      logic                 busy_o
);

  localparam int unsigned PW = HW + CNT_W;
  localparam int unsigned SW = (PW > AREA_W) ? PW : AREA_W;

  logic [PW-1:0]     prod_q;
  logic              prod_v_q;
  logic [AREA_W-1:0] best_q, best_d;
  logic [SW-1:0]     prod_ext;
  logic [AREA_W-1:0] area_sat;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pop) begin
      prod_q <= PW'(height_i) * PW'(width_i);
    end
  end

  always_comb begin
    prod_ext = SW'(prod_q);
    area_sat = (prod_ext > SW'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];
    best_d   = best_q;
    if (ctl_i.clr) begin
      best_d = '0;
    end else if (prod_v_q && (area_sat > best_q)) begin
      best_d = area_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      best_q   <= '0;
    end else begin
      prod_v_q <= ctl_i.pop;
      best_q   <= best_d;
    end
  end

  assign best_o = best_q;
  assign busy_o = prod_v_q;

endmodule

`default_nettype wire

[hw/rtl/largest_rectangle_of_ones.sv]
// Largest rectangle of ones in a binary matrix streamed one cell per transaction.
// Input channel: in_valid_i / in_stall_o carry cell_req_i and last_cell_i, cells in
// row-major order, rows num_cols wide (register 0 of the APB port, byte address 0).
// Output channel: out_valid_o / out_stall_i carry rect_area_o, one transaction per
// matrix, produced by the cell marked last_cell_i.
// Timing: one cell at a time. A cell passes through accept, height read-modify-write
// in the run height RAM and stack push, with one stack pop before the push for each
// taller entry; each column is popped once per row, and the row end flushes the
// stack. Pops share one stack RAM read port. The last cell then loads the result
// register once scoring is done, waiting while an earlier result is still stalled,
// then the run height RAM is cleared one entry a cycle up to the highest column used
// (at most MAX_COLS entries) before the next cell is taken.
// Reset: num_cols returns to 1024 and the block sweeps all MAX_COLS entries of
// the run height RAM, holding in_stall_o high until the sweep is done.
// A stalled result stays in the output register; the block keeps taking cells of
// the next matrix and only waits if the next result is ready before the old one
// is taken.
`default_nettype none

module largest_rectangle_of_ones
  import lro_pkg::*;
#(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic              cell_req_i,
  input  wire logic              last_cell_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [AREA_W-1:0] rect_area_o
);

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned CNT_W = $clog2(MAX_COLS + 1);
  localparam int unsigned HW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned EW    = CW + HW;

  localparam logic [CNT_W-1:0] COLS_MAX = CNT_W'(MAX_COLS);
  localparam logic [HW-1:0]    H_MAX    = HW'(MAX_ROWS);
  localparam logic [CW-1:0]    LAST_IDX = CW'(MAX_COLS - 1);

  lro_state_e        state_q, state_d;
  logic [CFG_W-1:0]  num_cols_q, num_cols_d;
  logic [CW-1:0]     col_pos_q, col_pos_d;
  logic [CW-1:0]     col_q, col_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [HW-1:0]     h_q, h_d;
  logic              cell_q, cell_d;
  logic              last_q, last_d;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic [EW-1:0]     top_q, top_d;
  logic [EW-1:0]     nxt_q, nxt_d;
  logic              rd_pend_q, rd_pend_d;
  logic [CW-1:0]     hwm_q, hwm_d;
  logic [CW-1:0]     clr_addr_q, clr_addr_d;
  logic [CW-1:0]     clr_end_q, clr_end_d;
  logic              out_valid_q, out_valid_d;
  logic [AREA_W-1:0] area_q, area_d;

  logic              rh_we;
  logic [CW-1:0]     rh_waddr, rh_raddr;
  logic [HW-1:0]     rh_wdata, rh_rdata;
  logic              st_we;
  logic [CW-1:0]     st_waddr, st_raddr;
  logic [EW-1:0]     st_wdata, st_rdata;

  lro_score_ctl_t    score_ctl;
  logic [HW-1:0]     pop_h;
  logic [CNT_W-1:0]  pop_w;
  logic [AREA_W-1:0] best;
  logic              score_busy;

  logic              cfg_wr;
  logic              cfg_hit;
  logic [CNT_W-1:0]  cols;
  logic [EW-1:0]     nxt_cur;
  logic [CNT_W-1:0]  col1;
  logic [CNT_W-1:0]  pop_j;
  logic [HW:0]       h_inc;
  logic              do_pop, do_push;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_AW-1:2] == REG_NUM_COLS);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = (psel && cfg_hit) ? APB_DW'(num_cols_q) : '0;

  always_comb begin
    num_cols_d = num_cols_q;
    if (cfg_wr) begin
      num_cols_d = pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (num_cols_q == '0) begin
      cols = CNT_W'(1);
    end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
      cols = COLS_MAX;
    end else begin
      cols = CNT_W'(num_cols_q);
    end
  end

  assign nxt_cur = rd_pend_q ? st_rdata : nxt_q;
  assign col1    = CNT_W'(col_q) + CNT_W'(1);
  assign h_inc   = (HW + 1)'(rh_rdata) + (HW + 1)'(1);

  always_comb begin
    state_d     = state_q;
    col_pos_d   = col_pos_q;
    col_d       = col_q;
    j_d         = j_q;
    h_d         = h_q;
    cell_d      = cell_q;
    last_d      = last_q;
    depth_d     = depth_q;
    top_d       = top_q;
    nxt_d       = nxt_cur;
    rd_pend_d   = 1'b0;
    hwm_d       = hwm_q;
    clr_addr_d  = clr_addr_q;
    clr_end_d   = clr_end_q;
    out_valid_d = out_valid_q && out_stall_i;
    area_d      = area_q;
    rh_we       = 1'b0;
    rh_waddr    = col_q;
    rh_wdata    = h_q;
    rh_raddr    = col_q;
    st_we       = 1'b0;
    st_waddr    = depth_q[CW-1:0];
    st_wdata    = {col_q, h_q};
    st_raddr    = '0;
    score_ctl   = '0;
    do_pop      = 1'b0;
    do_push     = 1'b0;
    pop_j       = j_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cell_d = cell_req_i;
          last_d = last_cell_i;
          if (CNT_W'(col_pos_q) >= cols) begin
            j_d     = CNT_W'(col_pos_q);
            col_d   = '0;
            state_d = S_PREFLUSH;
          end else begin
            col_d    = col_pos_q;
            rh_raddr = col_pos_q;
            state_d  = S_HGT;
          end
        end
      end
      S_PREFLUSH: begin
        if (depth_q != '0) begin
          do_pop = 1'b1;
        end else begin
          state_d = S_HGT;
        end
      end
      S_HGT: begin
        if (!cell_q) begin
          h_d = '0;
        end else if (h_inc > (HW + 1)'(H_MAX)) begin
          h_d = H_MAX;
        end else begin
          h_d = h_inc[HW-1:0];
        end
        rh_we    = 1'b1;
        rh_wdata = h_d;
        if (col_q > hwm_q) begin
          hwm_d = col_q;
        end
        state_d = S_POP;
      end
      S_POP: begin
        pop_j = CNT_W'(col_q);
        if ((depth_q != '0) && (top_q[HW-1:0] > h_q)) begin
          do_pop = 1'b1;
        end else begin
          do_push   = 1'b1;
          col_pos_d = (col1 >= cols) ? '0 : col1[CW-1:0];
          if ((col1 >= cols) || last_q) begin
            j_d     = col1;
            state_d = S_FLUSH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (depth_q != '0) begin
          do_pop = 1'b1;
        end else begin
          state_d = last_q ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (!score_busy && !(out_valid_q && out_stall_i)) begin
          out_valid_d   = 1'b1;
          area_d        = best;
          score_ctl.clr = 1'b1;
          col_pos_d     = '0;
          clr_addr_d    = '0;
          clr_end_d     = hwm_q;
          hwm_d         = '0;
          state_d       = S_CLEAR;
        end
      end
      S_CLEAR: begin
        rh_we    = 1'b1;
        rh_waddr = clr_addr_q;
        rh_wdata = '0;
        if (clr_addr_q == clr_end_q) begin
          state_d = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // pop: score the top entry against the entry below it
    pop_h = top_q[HW-1:0];
    if (depth_q >= CNT_W'(2)) begin
      pop_w = pop_j - CNT_W'(nxt_cur[EW-1:HW]) - CNT_W'(1);
    end else begin
      pop_w = pop_j;
    end
    if (do_pop) begin
      score_ctl.pop = 1'b1;
      depth_d       = depth_q - CNT_W'(1);
      top_d         = nxt_cur;
      if (depth_q >= CNT_W'(3)) begin
        st_raddr  = CW'(depth_q - CNT_W'(3));
        rd_pend_d = 1'b1;
      end
    end
    if (do_push) begin
      st_we   = 1'b1;
      nxt_d   = top_q;
      top_d   = {col_q, h_q};
      depth_d = depth_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      num_cols_q  <= CFG_W'(1024);
      col_pos_q   <= '0;
      depth_q     <= '0;
      rd_pend_q   <= 1'b0;
      hwm_q       <= '0;
      clr_addr_q  <= '0;
      clr_end_q   <= LAST_IDX;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_cols_q  <= num_cols_d;
      col_pos_q   <= col_pos_d;
      depth_q     <= depth_d;
      rd_pend_q   <= rd_pend_d;
      hwm_q       <= hwm_d;
      clr_addr_q  <= clr_addr_d;
      clr_end_q   <= clr_end_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    j_q    <= j_d;
    h_q    <= h_d;
    cell_q <= cell_d;
    top_q  <= top_d;
    nxt_q  <= nxt_d;
    area_q <= area_d;
  end

  lro_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_COLS)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (rh_we),
    .waddr_i (rh_waddr),
    .wdata_i (rh_wdata),
    .raddr_i (rh_raddr),
    .rdata_o (rh_rdata)
  );

  lro_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_COLS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  lro_score #(
    .HW    (HW),
    .CNT_W (CNT_W)
  ) u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (score_ctl),
    .height_i (pop_h),
    .width_i  (pop_w),
    .best_o   (best),
    .busy_o   (score_busy)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign rect_area_o = area_q;

  // stack never holds more entries than columns seen in this row
  a_depth_vs_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (depth_q <= CNT_W'(col_q)))
    else $error("stack deeper than current column");

  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= COLS_MAX)
    else $error("stack depth overflow");

  // a new result is only produced from an empty stack
  a_result_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) && (state_d == S_CLEAR) |-> (depth_q == '0) && !score_busy)
    else $error("result loaded with work pending");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !score_busy && !rd_pend_q)
    else $error("idle with pop pipeline active");

  a_clear_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (state_q == S_CLEAR) || (state_q == S_IDLE))
    else $error("clear pass left unexpectedly");

endmodule

`default_nettype wire

[tb/tb_largest_rectangle_of_ones.sv]
`default_nettype none

module tb_largest_rectangle_of_ones
  import lro_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_COLS       = 1024;
  localparam int unsigned MAX_ROWS       = 1024;
  localparam int unsigned SETTLE_CYC     = 2 * MAX_COLS + 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_CELLS   = 860;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [APB_AW-1:0] paddr      = '0;
  logic [APB_DW-1:0] pwdata     = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid   = 1'b0;
  logic              in_stall_o;
  logic              cell_req   = 1'b0;
  logic              last_cell  = 1'b0;
  logic              out_valid_o;
  logic              out_stall  = 1'b0;
  logic [AREA_W-1:0] rect_area_o;

  largest_rectangle_of_ones #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .cell_req_i (cell_req),
    .last_cell_i(last_cell),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .rect_area_o(rect_area_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the block: register, column heights, column stack, best area
  logic [CFG_W-1:0]  num_cols_q;
  logic [10:0]       col_height [MAX_COLS];
  logic [9:0]        col_stack  [MAX_COLS];
  int unsigned       stack_top;
  int unsigned       cur_col;
  logic [AREA_W-1:0] best_area;
  logic [AREA_W-1:0] area_q [$];

  int unsigned fail_cnt    = 0;
  int unsigned idle_cycles = 0;
  int unsigned rand_cells  = 0;
  bit          quiet       = 1'b0;

  function automatic int unsigned active_cols();
    if (num_cols_q == 0) return 1;
    if (num_cols_q > MAX_COLS) return MAX_COLS;
    return 32'(num_cols_q);
  endfunction

  function automatic void pop_score(int unsigned j);
    int unsigned       idx;
    int unsigned       width;
    longint unsigned   area;
    stack_top--;
    idx = 32'(col_stack[stack_top]);
    if (stack_top != 0) width = j - 32'(col_stack[stack_top-1]) - 1;
    else width = j;
    area = 64'(col_height[idx]);
    area = area * width;
    if (area > AREA_MAX) area = AREA_MAX;
    if (area > best_area) best_area = area[AREA_W-1:0];
  endfunction

  function automatic void flush_stack(int unsigned j);
    while (stack_top != 0) pop_score(j);
  endfunction

  function automatic void clear_matrix();
    for (int i = 0; i < MAX_COLS; i++) col_height[i] = '0;
    stack_top = 0;
    cur_col   = 0;
    best_area = '0;
  endfunction

  function automatic void rect_predict(bit cell_bit, bit last);
    int unsigned cols;
    int unsigned col;
    int unsigned h;
    cols = active_cols();
    col  = cur_col;
    if (col >= cols) begin
      flush_stack(col);
      col = 0;
    end
    if (cell_bit) begin
      h = 32'(col_height[col]);
      h = h + 1;
      if (h > MAX_ROWS) h = MAX_ROWS;
    end else begin
      h = 0;
    end
    col_height[col] = h[10:0];
    while (stack_top != 0 && col_height[col_stack[stack_top-1]] > h) pop_score(col);
    col_stack[stack_top] = col[9:0];
    stack_top++;
    if (col + 1 >= cols || last) flush_stack(col + 1);
    cur_col = (col + 1 >= cols) ? 0 : col + 1;
    if (last) begin
      area_q.push_back(best_area);
      clear_matrix();
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (area_q.size() == 0) begin
        $display("%0t: unexpected result transaction, actual rect_area %0d", $time,
                 rect_area_o);
        fail_cnt++;
      end else begin
        if (rect_area_o !== area_q[0]) begin
          $display("%0t: rect_area mismatch, expected %0d actual %0d", $time, area_q[0],
                   rect_area_o);
          fail_cnt++;
        end
        void'(area_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    int unsigned run;
    int unsigned r;
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(negedge clk_i);
      end else begin
        run = $urandom_range(1, 8);
        out_stall <= 1'b0;
        repeat (run) @(negedge clk_i);
        r = $urandom_range(0, 9);
        if (r < 6) run = $urandom_range(1, 2);
        else if (r < 9) run = $urandom_range(3, 6);
        else run = $urandom_range(20, 60);
        out_stall <= 1'b1;
        repeat (run) @(negedge clk_i);
      end
    end
  end

  task automatic send_cell(input bit cell_bit, input bit last);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(5, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cell_req  <= cell_bit;
    last_cell <= last;
    in_valid  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rect_predict(cell_bit, last);
    @(negedge clk_i);
  endtask

  task automatic reg_write(input lro_reg_e r, input logic [APB_DW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (r == REG_NUM_COLS) num_cols_q = d[CFG_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic reg_read_check(input lro_reg_e r);
    logic [APB_DW-1:0] exp_data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    exp_data = '0;
    exp_data[CFG_W-1:0] = num_cols_q;
    if (prdata !== exp_data) begin
      $display("%0t: num_cols read mismatch, expected %0d actual %0d", $time, exp_data,
               prdata);
      fail_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for every outstanding result, then let the block finish flushing and clearing
  task automatic settle();
    in_valid <= 1'b0;
    while (area_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic test_reset_default();
    reg_read_check(REG_NUM_COLS);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_cols_extremes();
    reg_write(REG_NUM_COLS, 0);
    reg_read_check(REG_NUM_COLS);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
    reg_write(REG_NUM_COLS, 2047);
    reg_read_check(REG_NUM_COLS);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
    reg_write(REG_NUM_COLS, 1);
    send_cell(1'b0, 1'b1);
    settle();
  endtask

  task automatic test_midrow_last();
    reg_write(REG_NUM_COLS, 4);
    repeat (4) send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_cols_lowered_midrow();
    reg_write(REG_NUM_COLS, 6);
    repeat (5) send_cell(1'b1, 1'b0);
    settle();
    reg_write(REG_NUM_COLS, 3);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_random_matrices();
    int unsigned cols;
    int unsigned nmat;
    int unsigned rows;
    int unsigned dens;
    int unsigned ncell;
    int unsigned r;
    while (rand_cells < RANDOM_CELLS) begin
      r = $urandom_range(0, 19);
      if (r == 0) cols = 0;
      else if (r == 1) cols = $urandom_range(13, 64);
      else cols = $urandom_range(1, 12);
      settle();
      reg_write(REG_NUM_COLS, cols);
      quiet = ($urandom_range(0, 3) == 0);
      nmat = $urandom_range(1, 5);
      for (int m = 0; m < nmat; m++) begin
        rows = (active_cols() > 12) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        case ($urandom_range(0, 4))
          0: dens = 30;
          1: dens = 50;
          2: dens = 75;
          3: dens = 90;
          default: dens = 100;
        endcase
        ncell = rows * active_cols();
        if ($urandom_range(0, 4) == 0) ncell = $urandom_range(1, ncell);
        for (int k = 0; k < ncell; k++) begin
          send_cell($urandom_range(0, 99) < dens, k == ncell - 1);
        end
        rand_cells += ncell;
      end
      // leave a matrix unfinished so the next column count lands mid-row
      if ($urandom_range(0, 5) == 0) begin
        ncell = $urandom_range(1, 2 * active_cols());
        repeat (ncell) send_cell($urandom_range(0, 1), 1'b0);
        rand_cells += ncell;
      end
    end
    quiet = 1'b0;
    settle();
  endtask

  initial begin
    num_cols_q = 11'd1024;
    clear_matrix();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_default();
    test_cols_extremes();
    test_midrow_last();
    test_cols_lowered_midrow();
    test_random_matrices();
    if (fail_cnt == 0 && area_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
